/* hdl/nqse_pkg.sv */
// Shared types and constants for the N-queens solution enumerator.
package nqse_pkg;

   localparam int MaxN   = 16;
   localparam int ColW   = 4;
   localparam int RowW   = 4;
   localparam int SizeW  = 5;
   localparam int PlaceW = MaxN * ColW;

   localparam logic [SizeW-1:0] SizeReset = SizeW'(8);

   typedef logic [MaxN-1:0] mask_vec_type;

   // Squares of the next row attacked by the queens placed so far.
   typedef struct packed {
      mask_vec_type cols;
      mask_vec_type ldiag;
      mask_vec_type rdiag;
   } attack_type;

   typedef struct packed {
      logic            wr_en;
      logic [ColW-1:0] col;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DELIVER
   } state_type;

endpackage

/* hdl/nqse_cell.sv */
// One board row: holds its queen column and the attack masks it passes upward.
module nqse_cell import nqse_pkg::*; (
   input  logic            clock,
   input  cell_ctl_type    ctl,
   input  attack_type      atk_prev,
   output attack_type      atk_next,
   output logic [ColW-1:0] col_q
);

   logic [ColW-1:0] col_ff;
   attack_type      atk_ff;
   attack_type      atk_in;
   mask_vec_type    queen;

   always_comb begin
      queen        = mask_vec_type'(1) << ctl.col;
      atk_in.cols  = atk_prev.cols | queen;
      atk_in.ldiag = (atk_prev.ldiag | queen) << 1;
      atk_in.rdiag = (atk_prev.rdiag | queen) >> 1;
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         col_ff <= ctl.col;
         atk_ff <= atk_in;
      end
   end

   assign atk_next = atk_ff;
   assign col_q    = col_ff;

endmodule

/* hdl/n_queens_solution_enumerator.sv */
// Top level of the N-queens solution enumerator: search sequencer and row cells.
//
//   port group | dir | payload                          | handshake
//   req_       | in  | tdata[0] restart                 | tvalid/tready
//   rsp_       | out | tdata placement, tuser found     | tvalid/tready
//   csr_       | in  | wr_data board_size               | wr_en, no wait
//
// One backtracking step (place, advance column, or back up a row) per cycle.
// A request runs S search steps, S the steps to the next solution or exhaustion,
// then a delivery state; exhausted or size-zero requests skip the search.
// Reset is synchronous; no clearing pass is needed.
// A result waits in the output register; a new request is taken meanwhile, and
// the block stalls only when a second result is ready before the first is taken.
module n_queens_solution_enumerator import nqse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,    // [0] restart, [7:1] zero
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [PlaceW-1:0] rsp_tdata,    // [63:0] placement
   output logic              rsp_tuser,    // [0] found
   input  logic              csr_wr_en,
   input  logic [SizeW-1:0]  csr_wr_data
);

   state_type         state_ff, state_in;
   logic [SizeW-1:0]  size_ff, size_in;
   logic [RowW-1:0]   row_ff, row_in;
   logic [SizeW-1:0]  col_ff, col_in;
   logic              exh_ff, exh_in;
   logic              started_ff, started_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PlaceW-1:0] rsp_place_ff, rsp_place_in;
   logic              rsp_found_ff, rsp_found_in;

   logic [SizeW-1:0]  n;
   logic [RowW-1:0]   n_m1;
   logic              cell_we;
   cell_ctl_type      ctl     [MaxN];
   attack_type        atk_out [MaxN];
   logic [ColW-1:0]   cell_col[MaxN];
   attack_type        atk_sel;
   mask_vec_type      attacked;
   logic              free;
   logic [PlaceW-1:0] packed_place;

   assign n    = (size_ff > SizeW'(MaxN)) ? SizeW'(MaxN) : size_ff;
   assign n_m1 = RowW'(n - SizeW'(1));

   genvar gi;
   generate
      for (gi = 0; gi < MaxN; gi++) begin : g_cell
         assign ctl[gi].wr_en = cell_we && (row_ff == RowW'(gi));
         assign ctl[gi].col   = col_ff[ColW-1:0];
         if (gi == 0) begin : g_first
            nqse_cell u_cell (
               .clock    (clock),
               .ctl      (ctl[gi]),
               .atk_prev ('0),
               .atk_next (atk_out[gi]),
               .col_q    (cell_col[gi])
            );
         end else begin : g_rest
            nqse_cell u_cell (
               .clock    (clock),
               .ctl      (ctl[gi]),
               .atk_prev (atk_out[gi-1]),
               .atk_next (atk_out[gi]),
               .col_q    (cell_col[gi])
            );
         end
         assign packed_place[gi*ColW +: ColW] =
            (SizeW'(gi) < n) ? cell_col[gi] : '0;
      end
   endgenerate

   // masks seen by the current row come from the cell just below it
   assign atk_sel  = (row_ff == '0) ? '0 : atk_out[row_ff - RowW'(1)];
   assign attacked = atk_sel.cols | atk_sel.ldiag | atk_sel.rdiag;
   assign free     = !attacked[col_ff[ColW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SizeReset;
         row_ff       <= '0;
         col_ff       <= '0;
         exh_ff       <= 1'b0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         exh_ff       <= exh_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff     <= found_in;
      rsp_place_ff <= rsp_place_in;
      rsp_found_ff <= rsp_found_in;
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      exh_in       = exh_ff;
      started_in   = started_ff;
      found_in     = found_ff;
      rsp_place_in = rsp_place_ff;
      rsp_found_in = rsp_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cell_we      = 1'b0;
      req_tready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tdata[0]) begin
                  row_in     = '0;
                  col_in     = '0;
                  exh_in     = 1'b0;
                  started_in = 1'b0;
               end
               if (n == '0) begin
                  exh_in = 1'b1;
               end
               if (exh_in) begin
                  found_in = 1'b0;
                  state_in = ST_DELIVER;
               end else begin
                  if (!started_in) begin
                     started_in = 1'b1;
                     row_in     = '0;
                     col_in     = '0;
                  end
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (col_ff >= n) begin
               if (row_ff == '0) begin
                  exh_in   = 1'b1;
                  col_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_DELIVER;
               end else begin
                  // back up: resume one past the queen of the row below
                  row_in = row_ff - RowW'(1);
                  col_in = {1'b0, cell_col[row_ff - RowW'(1)]} + SizeW'(1);
               end
            end else if (free) begin
               cell_we = 1'b1;
               if (row_ff == n_m1) begin
                  found_in = 1'b1;
                  col_in   = col_ff + SizeW'(1);
                  state_in = ST_DELIVER;
               end else begin
                  row_in = row_ff + RowW'(1);
                  col_in = '0;
               end
            end else begin
               col_in = col_ff + SizeW'(1);
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_place_in = found_ff ? packed_place : '0;
               rsp_found_in = found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a size write also restarts the search
      if (csr_wr_en) begin
         size_in    = csr_wr_data;
         row_in     = '0;
         col_in     = '0;
         exh_in     = 1'b0;
         started_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_place_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

/* hdl/nqse_checker.sv */
// Port-level checks for the N-queens solution enumerator, bound to the top level.
module nqse_checker import nqse_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [PlaceW-1:0] rsp_tdata,
   input logic              rsp_tuser
);

   // a result not taken stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // exhausted search reports an empty placement
   a_empty_when_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("placement not zero on exhausted search");

   // the search occupies the block after a request
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while search in progress");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a found placement with its second queen off column 0 never has the first two queens touching
   a_rows_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata[7:4] != 4'd0 |->
         rsp_tdata[3:0] != rsp_tdata[7:4] &&
         {1'b0, rsp_tdata[3:0]} + 5'd1 != {1'b0, rsp_tdata[7:4]} &&
         {1'b0, rsp_tdata[7:4]} + 5'd1 != {1'b0, rsp_tdata[3:0]})
      else $error("first two rows attack each other");

endmodule

bind n_queens_solution_enumerator nqse_checker u_nqse_checker (.*);

/* tb/tb_n_queens_solution_enumerator.sv */
// Testbench for the N-queens solution enumerator: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module tb_n_queens_solution_enumerator;
   import nqse_pkg::*;

   localparam int CycleLimit  = 20_000_000;
   localparam int HoldCycles  = 400;
   localparam int RandomItems = 630;

   // Tracks the backtracking search and keeps the answers still owed by the block.
   class queens_scoreboard;
      typedef struct {
         logic [PlaceW-1:0] placement;
         logic              found;
      } answer_type;

      logic [SizeW-1:0] size_reg;
      logic [ColW-1:0]  cols [MaxN];
      int               cur_row;
      int               next_col;
      bit               exhausted;
      bit               started;
      answer_type       answers_due [$];
      int               requests;
      int               restarts;
      int               found_count;
      int               exhausted_count;
      int               mismatches;

      function new();
         size_reg = SizeReset;
         foreach (cols[i]) cols[i] = '0;
         clear_search();
      endfunction

      function void clear_search();
         cur_row   = 0;
         next_col  = 0;
         exhausted = 0;
         started   = 0;
      endfunction

      function void set_size(logic [SizeW-1:0] value);
         size_reg = value;
         clear_search();
      endfunction

      function bit square_safe(int row, int col);
         int q;
         int d;
         for (int i = 0; i < row; i++) begin
            q = int'(cols[i]);
            d = row - i;
            if (q == col || q + d == col || col + d == q) return 0;
         end
         return 1;
      endfunction

      // Runs the search forward to the next placement, or to exhaustion.
      function void note_request(logic restart);
         answer_type ans;
         int n;
         int row;
         int col;
         bit done;
         requests++;
         n = (int'(size_reg) > MaxN) ? MaxN : int'(size_reg);
         if (restart) begin
            restarts++;
            clear_search();
         end
         ans.placement = '0;
         ans.found     = 1'b0;
         if (n == 0) exhausted = 1;
         if (!exhausted) begin
            if (!started) begin
               started  = 1;
               cur_row  = 0;
               next_col = 0;
            end
            row  = cur_row;
            col  = next_col;
            if (row >= n) row = n - 1;
            done = 0;
            while (!done) begin
               if (col >= n) begin
                  if (row == 0) begin
                     exhausted = 1;
                     cur_row   = 0;
                     next_col  = 0;
                     done      = 1;
                  end else begin
                     row--;
                     col = int'(cols[row]) + 1;
                  end
               end else if (square_safe(row, col)) begin
                  cols[row] = col[ColW-1:0];
                  if (row == n - 1) begin
                     for (int r = 0; r < n; r++) ans.placement[ColW*r +: ColW] = cols[r];
                     ans.found = 1'b1;
                     cur_row   = row;
                     next_col  = col + 1;
                     done      = 1;
                  end else begin
                     row++;
                     col = 0;
                  end
               end else begin
                  col++;
               end
            end
         end
         answers_due.push_back(ans);
      endfunction

      function void check_result(logic [PlaceW-1:0] placement, logic found);
         answer_type ans;
         if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: placement %h found %0b", placement, found);
            return;
         end
         ans = answers_due.pop_front();
         if (ans.found) found_count++;
         else exhausted_count++;
         if (placement !== ans.placement || found !== ans.found) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: placement exp %h got %h, found exp %0b got %0b",
                        ans.placement, placement, ans.found, found);
         end
      endfunction

      function int pending();
         return answers_due.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [7:0]        req_tdata;    // [0] restart, [7:1] zero
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [PlaceW-1:0] rsp_tdata;    // [63:0] placement
   logic              rsp_tuser;    // [0] found
   logic              csr_wr_en;
   logic [SizeW-1:0]  csr_wr_data;

   queens_scoreboard sb;
   int               cycle_count = 0;
   int               size_writes = 0;
   bit               req_steady  = 0;
   bit               rsp_steady  = 0;
   bit               rsp_hold    = 0;

   n_queens_solution_enumerator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Check results before noting requests so a same-edge request never meets its own result.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready) sb.note_request(req_tdata[0]);
      end
   end

   // Receiver: random stalls, steady stretches, and one long hold-off on request.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            rsp_hold = 0;
         end
         if ($urandom_range(0, 39) == 0) rsp_steady = ~rsp_steady;
         gap = rsp_steady ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // valid stays high across back-to-back requests; it drops only ahead of a gap
   task automatic send_request(input logic restart);
      int gap;
      if ($urandom_range(0, 39) == 0) req_steady = ~req_steady;
      gap = req_steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, restart};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // board_size is only written once every answer is back; the first edge lets the
   // monitor note the last request before the count is read
   task automatic write_size(input logic [SizeW-1:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_size(value);
      size_writes++;
   endtask

   initial begin
      int sent;
      int count;
      int sel;
      int size;
      int restart_odds;
      sb          = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default size 8, searching before any restart
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      write_size(5'd1);
      send_request(1'b0);
      send_request(1'b0);
      write_size(5'd0);
      send_request(1'b0);
      send_request(1'b1);
      write_size(5'd2);
      send_request(1'b0);
      write_size(5'd3);
      send_request(1'b1);
      write_size(5'd16);
      send_request(1'b1);
      send_request(1'b0);
      write_size(5'd31);
      send_request(1'b0);
      write_size(5'd17);
      send_request(1'b0);
      // rewriting the same size mid-search starts over
      write_size(5'd4);
      send_request(1'b0);
      write_size(5'd4);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);

      // fill the block while the receiver holds off
      write_size(5'd5);
      rsp_hold = 1;
      sent = 0;
      repeat (30) begin
         send_request($urandom_range(0, 5) == 0);
         sent++;
      end

      while (sent < RandomItems) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) size = 0;
         else if (sel == 1) size = $urandom_range(17, 31);
         else if (sel == 2) size = 16;
         else if (sel <= 5) size = $urandom_range(9, 15);
         else size = $urandom_range(1, 8);
         write_size(size[SizeW-1:0]);
         count        = (size >= 1 && size <= 8) ? $urandom_range(8, 40) : $urandom_range(5, 20);
         restart_odds = (size >= 1 && size <= 12) ? 8 : 30;
         repeat (count) begin
            send_request($urandom_range(1, restart_odds) == 1);
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Covered %0d requests (%0d restarts) across %0d board-size writes",
               sb.requests, sb.restarts, size_writes);
      $display("Checked %0d solutions and %0d exhausted answers, %0d mismatches",
               sb.found_count, sb.exhausted_count, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
